[rtl/hte_pkg.sv]
package hte_pkg;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int TOT_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 7;
  localparam int CNT_W   = 3;
  localparam int DEPTH   = 256;
  localparam int MAX_OUT = 4;
  // Pending bits plus the longest code, rounded up to whole bytes.
  localparam int ACC_W   = 40;
  localparam int LEFT_W  = 3;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic   hit;
    entry_t ent;
  } rd_t;

  typedef struct packed {
    logic load;
    logic encode;
  } s1_ctrl_t;

endpackage

[rtl/hte_if.sv]
interface hte_in_if;
  logic                        valid;
  logic                        ready;
  logic [hte_pkg::OP_W-1:0]    operation;
  logic [hte_pkg::SYM_W-1:0]   symbol;
  logic [hte_pkg::CODE_W-1:0]  code_value;
  logic [hte_pkg::LEN_W-1:0]   code_length;
  logic                        entry_valid;

  modport source (output valid, operation, symbol, code_value, code_length, entry_valid,
                  input ready);
  modport sink (input valid, operation, symbol, code_value, code_length, entry_valid,
                output ready);
endinterface

interface hte_out_if;
  logic                        valid;
  logic                        ready;
  logic [hte_pkg::BYTE_W-1:0]  packed_byte;
  logic                        byte_present;
  logic                        last_of_run;
  logic [hte_pkg::TOT_W-1:0]   bit_count;

  modport source (output valid, packed_byte, byte_present, last_of_run, bit_count,
                  input ready);
  modport sink (input valid, packed_byte, byte_present, last_of_run, bit_count,
                output ready);
endinterface

[rtl/hte_table.sv]
module hte_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [hte_pkg::SYM_W-1:0] wr_addr,
  input  logic                      wr_valid,
  input  hte_pkg::entry_t           wr_ent,
  input  logic                      rd_en,
  input  logic [hte_pkg::SYM_W-1:0] rd_addr,
  output hte_pkg::rd_t              rd_data
);
  import hte_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  entry_t           rd_ent_r;
  logic             rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent_r <= mem[rd_addr];
    end
  end

  // Valid bits live in flops so reset invalidates the whole table at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= wr_valid;
      end
      if (rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = '{hit: rd_hit_r, ent: rd_ent_r};

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("table written and read in the same cycle");

  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(wr_addr)] == $past(wr_valid))
    else $error("valid bit not updated by a table write");

  a_read_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> rd_hit_r == valid_r[$past(rd_addr)])
    else $error("registered hit disagrees with the valid bit");

endmodule

[rtl/hte_packer.sv]
module hte_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  hte_pkg::s1_ctrl_t s1_ctrl,
  input  hte_pkg::rd_t      rd_data,
  output logic              s1_free,
  hte_out_if.source         out_if
);
  import hte_pkg::*;

  logic              s1_valid_r;
  logic              s1_enc_r;
  logic [PEND_W-1:0] pend_r;
  logic [CNT_W-1:0]  pcnt_r;
  logic [TOT_W-1:0]  tot_r;

  logic              g_valid_r;
  logic [LEFT_W-1:0] g_left_r;
  logic              g_present_r;
  logic [TOT_W-1:0]  g_tot_r;
  logic [BYTE_W-1:0] g_bytes_r [MAX_OUT];

  logic [CODE_W-1:0] code_m;
  logic [ACC_W-1:0]  v_w;
  logic [ACC_W-1:0]  a_w;
  logic [LEN_W-1:0]  t_w;
  logic [CNT_W-1:0]  n_w;
  logic [CNT_W-1:0]  ncnt_w;
  logic [PEND_W-1:0] npend_w;
  logic [TOT_W-1:0]  ntot_w;
  logic [BYTE_W-1:0] f_byte;
  logic              enc_hit;
  logic              s1_flush;
  logic              has_group;
  logic              take;
  logic              g_last;
  logic              g_free;
  logic              s1_adv;

  // Append the code behind the pending bits, then left-align the whole run
  // so completed bytes sit at fixed positions from the top.
  always_comb begin
    code_m  = rd_data.ent.code & ~({CODE_W{1'b1}} << rd_data.ent.len);
    v_w     = ({{(ACC_W-PEND_W){1'b0}}, pend_r} << rd_data.ent.len)
              | {{(ACC_W-CODE_W){1'b0}}, code_m};
    t_w     = {{(LEN_W-CNT_W){1'b0}}, pcnt_r} + rd_data.ent.len;
    a_w     = v_w << (LEN_W'(ACC_W) - t_w);
    n_w     = t_w[LEN_W-1:3];
    ncnt_w  = t_w[2:0];
    npend_w = v_w[PEND_W-1:0] & ~({PEND_W{1'b1}} << ncnt_w);
    ntot_w  = tot_r + {{(TOT_W-LEN_W){1'b0}}, rd_data.ent.len};
    f_byte  = {1'b0, pend_r} << (4'(BYTE_W) - {1'b0, pcnt_r});
  end

  assign enc_hit   = s1_valid_r && s1_enc_r && rd_data.hit;
  assign s1_flush  = s1_valid_r && !s1_enc_r;
  assign has_group = s1_flush || (enc_hit && (n_w != '0));
  assign take      = g_valid_r && out_if.ready;
  assign g_last    = (g_left_r == LEFT_W'(1));
  assign g_free    = !g_valid_r || (take && g_last);
  assign s1_adv    = s1_valid_r && (!has_group || g_free);
  assign s1_free   = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_enc_r   <= 1'b0;
      pend_r     <= '0;
      pcnt_r     <= '0;
      tot_r      <= '0;
      g_valid_r  <= 1'b0;
      g_left_r   <= '0;
    end else begin
      if (s1_ctrl.load) begin
        s1_valid_r <= 1'b1;
        s1_enc_r   <= s1_ctrl.encode;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv && s1_flush) begin
        pend_r <= '0;
        pcnt_r <= '0;
        tot_r  <= '0;
      end else if (s1_adv && enc_hit) begin
        pend_r <= npend_w;
        pcnt_r <= ncnt_w;
        tot_r  <= ntot_w;
      end

      if (s1_adv && has_group) begin
        g_valid_r <= 1'b1;
        g_left_r  <= s1_flush ? LEFT_W'(1) : n_w;
      end else if (take) begin
        g_valid_r <= !g_last;
        g_left_r  <= g_left_r - LEFT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_group) begin
      if (s1_flush) begin
        g_tot_r      <= tot_r;
        g_present_r  <= (pcnt_r != '0);
        g_bytes_r[0] <= f_byte;
      end else begin
        g_present_r <= 1'b1;
        g_tot_r     <= ntot_w;
        for (int k = 0; k < MAX_OUT; k++) begin
          g_bytes_r[k] <= a_w[ACC_W-1-BYTE_W*k -: BYTE_W];
        end
      end
    end else if (take) begin
      for (int k = 0; k < MAX_OUT-1; k++) begin
        g_bytes_r[k] <= g_bytes_r[k+1];
      end
    end
  end

  assign out_if.valid        = g_valid_r;
  assign out_if.packed_byte  = g_bytes_r[0];
  assign out_if.byte_present = g_present_r;
  assign out_if.last_of_run  = g_last;
  assign out_if.bit_count    = g_tot_r;

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_valid_r |-> (g_left_r != '0) && (g_left_r <= LEFT_W'(MAX_OUT)))
    else $error("output group count out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_flush) |=> (tot_r == '0) && (pcnt_r == '0) && (pend_r == '0))
    else $error("flush did not clear the pending state");

  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (g_valid_r && !g_present_r) |-> g_last && (g_bytes_r[0] == '0))
    else $error("empty flush result malformed");

endmodule

[rtl/huffman_table_encoder_packer_unit.sv]
// Huffman encoder with a loaded 256-entry code table. A load transaction writes one
// entry (code up to 32 bits, length clipped to the smaller of MAX_CODE_LEN and 32) and
// yields no result. An encode transaction packs the symbol's code MSB first behind the
// pending bits and returns one result per completed byte (zero to four); a flush returns
// the pending bits left-aligned with the bit total and then clears both. The input side
// takes one transaction per clock while the packer stage is free: the table read is
// registered in the synchronous table memory, then the packer stage folds the code into
// the pending byte. A transaction that produces k results holds the single output
// register until all k have been taken, and the packer stage waits only while the output
// register still holds an earlier transaction's results.
// The table's valid bits are flops cleared by reset; no clearing pass is needed.
module huffman_table_encoder_packer_unit #(
  parameter int MAX_CODE_LEN = 32
) (
  input logic      clk,
  input logic      rst_n,
  hte_in_if.sink   in_if,
  hte_out_if.source out_if
);
  import hte_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

  logic       in_acc;
  logic       s1_free;
  entry_t     wr_ent;
  logic [LEN_W-1:0] cap_len;
  rd_t        rd_data;
  s1_ctrl_t   s1_ctrl;

  // Nothing is taken while reset is held.
  assign in_if.ready = s1_free && rst_n;
  assign in_acc      = in_if.valid && in_if.ready;

  assign cap_len = (in_if.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                          : in_if.code_length;
  // A cleared entry stores zeros in place of its code and length.
  assign wr_ent = in_if.entry_valid ? '{len: cap_len, code: in_if.code_value}
                                    : '{len: '0, code: '0};

  assign s1_ctrl.load   = in_acc && ((in_if.operation == OP_ENCODE)
                                  || (in_if.operation == OP_FLUSH));
  assign s1_ctrl.encode = (in_if.operation == OP_ENCODE);

  hte_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc && (in_if.operation == OP_LOAD)),
    .wr_addr  (in_if.symbol),
    .wr_valid (in_if.entry_valid),
    .wr_ent   (wr_ent),
    .rd_en    (in_acc && (in_if.operation == OP_ENCODE)),
    .rd_addr  (in_if.symbol),
    .rd_data  (rd_data)
  );

  hte_packer u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_ctrl (s1_ctrl),
    .rd_data (rd_data),
    .s1_free (s1_free),
    .out_if  (out_if)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import hte_pkg::*;

  localparam int MAX_LEN = 32;
  localparam int LEN_CAP = (MAX_LEN > 32) ? 32 : MAX_LEN;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_CYCLES = 200;
  localparam int N_ROWS = 24;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              ev;
  } sym_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pbyte;
    logic              present;
    logic              last_run;
    logic [TOT_W-1:0]  total;
  } packed_out_t;

  typedef struct packed {
    sym_cmd_t    cmd;
    logic        typed;
    packed_out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hte_in_if  in_ch ();
  hte_out_if out_ch ();

  huffman_table_encoder_packer_unit #(.MAX_CODE_LEN(MAX_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  // Predicted encoder state.
  logic              tbl_ok   [DEPTH];
  logic [CODE_W-1:0] tbl_code [DEPTH];
  logic [LEN_W-1:0]  tbl_len  [DEPTH];
  logic [PEND_W-1:0] pend_bits;
  logic [CNT_W-1:0]  pend_cnt;
  logic [TOT_W-1:0]  bit_sum;

  packed_out_t scratch_q [$];
  packed_out_t exp_bytes_q [$];

  int errors = 0;
  int cycles = 0;
  int n_load = 0;
  int n_encode = 0;
  int n_flush = 0;
  int n_ignored = 0;
  int n_bytes_checked = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  logic stall_req = 1'b0;
  logic stall_taken = 1'b0;
  int stall_left = 0;

  dir_row_t dir_rows [N_ROWS];

  function automatic dir_row_t mkrow(input logic [OP_W-1:0] op, input int sym,
                                     input logic [CODE_W-1:0] code, input int len,
                                     input bit ev, input bit typed,
                                     input int pbyte, input bit present,
                                     input logic [TOT_W-1:0] total);
    dir_row_t r;
    r.cmd.op = op;
    r.cmd.sym = SYM_W'(sym);
    r.cmd.code = code;
    r.cmd.len = LEN_W'(len);
    r.cmd.ev = ev;
    r.typed = typed;
    r.want.pbyte = BYTE_W'(pbyte);
    r.want.present = present;
    r.want.last_run = 1'b1;
    r.want.total = total;
    return r;
  endfunction

  // Works out the bytes a transaction produces and advances the predicted state.
  task automatic huff_predict(input sym_cmd_t c);
    logic [BYTE_W-1:0] acc;
    int cnt;
    logic [LEN_W-1:0] l;
    logic [CODE_W-1:0] cw;
    logic [TOT_W-1:0] sum;
    packed_out_t r;
    scratch_q.delete();
    case (c.op)
      OP_LOAD: begin
        n_load++;
        if (c.ev) begin
          tbl_ok[c.sym] = 1'b1;
          tbl_code[c.sym] = c.code;
          tbl_len[c.sym] = (int'(c.len) > LEN_CAP) ? LEN_W'(LEN_CAP) : c.len;
        end else begin
          tbl_ok[c.sym] = 1'b0;
          tbl_code[c.sym] = '0;
          tbl_len[c.sym] = '0;
        end
      end
      OP_ENCODE: begin
        n_encode++;
        if (tbl_ok[c.sym]) begin
          l = tbl_len[c.sym];
          cw = tbl_code[c.sym];
          acc = {1'b0, pend_bits};
          cnt = int'(pend_cnt);
          sum = bit_sum + TOT_W'(l);
          for (int i = int'(l); i > 0; i--) begin
            acc = {acc[BYTE_W-2:0], cw[i-1]};
            cnt++;
            if (cnt == 8) begin
              r.pbyte = acc;
              r.present = 1'b1;
              r.last_run = 1'b0;
              r.total = sum;
              scratch_q.push_back(r);
              acc = '0;
              cnt = 0;
            end
          end
          if (scratch_q.size() > 0) scratch_q[scratch_q.size()-1].last_run = 1'b1;
          pend_bits = acc[PEND_W-1:0];
          pend_cnt = CNT_W'(cnt);
          bit_sum = sum;
        end
      end
      OP_FLUSH: begin
        n_flush++;
        acc = {1'b0, pend_bits};
        r.pbyte = (pend_cnt != 0) ? BYTE_W'(acc << (4'd8 - 4'(pend_cnt))) : '0;
        r.present = (pend_cnt != 0);
        r.last_run = 1'b1;
        r.total = bit_sum;
        scratch_q.push_back(r);
        pend_bits = '0;
        pend_cnt = '0;
        bit_sum = '0;
      end
      default: n_ignored++;
    endcase
  endtask

  // Offers one transaction, waits for the handshake, then records what it should produce.
  // A typed row replaces the predicted result with the one written in the table.
  task automatic send_cmd(input sym_cmd_t c, input logic typed, input packed_out_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= c.op;
    in_ch.symbol <= c.sym;
    in_ch.code_value <= c.code;
    in_ch.code_length <= c.len;
    in_ch.entry_valid <= c.ev;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    huff_predict(c);
    if (typed) exp_bytes_q.push_back(want);
    else foreach (scratch_q[k]) exp_bytes_q.push_back(scratch_q[k]);
  endtask

  function automatic sym_cmd_t random_cmd();
    sym_cmd_t c;
    int r;
    r = $urandom_range(99);
    if (r < 28) c.op = OP_LOAD;
    else if (r < 87) c.op = OP_ENCODE;
    else if (r < 96) c.op = OP_FLUSH;
    else c.op = OP_UNUSED;
    // A narrow symbol range keeps most encodes hitting loaded entries.
    c.sym = ($urandom_range(9) == 0) ? SYM_W'($urandom_range(255)) : SYM_W'($urandom_range(15));
    c.code = $urandom;
    c.len = ($urandom_range(9) < 8) ? LEN_W'($urandom_range(32)) : LEN_W'($urandom_range(63));
    c.ev = ($urandom_range(9) != 0);
    return c;
  endfunction

  // Receiver: random ready, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req && !stall_taken) begin
      out_ch.ready <= 1'b0;
      stall_taken <= 1'b1;
      stall_left <= STALL_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin : chk
    packed_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_bytes_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction: byte %h present %b last %b total %h", $time,
                 out_ch.packed_byte, out_ch.byte_present, out_ch.last_of_run,
                 out_ch.bit_count);
      end else begin
        want = exp_bytes_q.pop_front();
        n_bytes_checked++;
        if (out_ch.packed_byte !== want.pbyte ||
            out_ch.byte_present !== want.present ||
            out_ch.last_of_run !== want.last_run ||
            out_ch.bit_count !== want.total) begin
          errors++;
          if (out_ch.packed_byte !== want.pbyte)
            $display("%0t: packed_byte expected %h actual %h", $time, want.pbyte,
                     out_ch.packed_byte);
          if (out_ch.byte_present !== want.present)
            $display("%0t: byte_present expected %b actual %b", $time, want.present,
                     out_ch.byte_present);
          if (out_ch.last_of_run !== want.last_run)
            $display("%0t: last_of_run expected %b actual %b", $time, want.last_run,
                     out_ch.last_of_run);
          if (out_ch.bit_count !== want.total)
            $display("%0t: bit_count expected %h actual %h", $time, want.total,
                     out_ch.bit_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, exp_bytes_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    packed_out_t none;
    int phase_items;
    int target;
    sym_cmd_t c;
    none = '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.symbol <= '0;
    in_ch.code_value <= '0;
    in_ch.code_length <= '0;
    in_ch.entry_valid <= 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_ok[i] = 1'b0;
      tbl_code[i] = '0;
      tbl_len[i] = '0;
    end
    pend_bits = '0;
    pend_cnt = '0;
    bit_sum = '0;

    dir_rows[0]  = mkrow(OP_FLUSH,    0, 32'h0,        0, 0, 1, 8'h00, 0, 32'd0);
    dir_rows[1]  = mkrow(OP_ENCODE,   0, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[2]  = mkrow(OP_UNUSED, 255, 32'hFFFFFFFF, 63, 1, 0, 0, 0, 0);
    dir_rows[3]  = mkrow(OP_LOAD,     0, 32'hFFFFFFFF, 32, 1, 0, 0, 0, 0);
    dir_rows[4]  = mkrow(OP_ENCODE,   0, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[5]  = mkrow(OP_LOAD,   255, 32'h000000FF, 8, 1, 0, 0, 0, 0);
    dir_rows[6]  = mkrow(OP_ENCODE, 255, 32'h0,        0, 0, 1, 8'hFF, 1, 32'd40);
    dir_rows[7]  = mkrow(OP_FLUSH,    0, 32'h0,        0, 0, 1, 8'h00, 0, 32'd40);
    dir_rows[8]  = mkrow(OP_LOAD,     1, 32'h0000000A, 4, 1, 0, 0, 0, 0);
    dir_rows[9]  = mkrow(OP_ENCODE,   1, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[10] = mkrow(OP_FLUSH,    0, 32'h0,        0, 0, 1, 8'hA0, 1, 32'd4);
    // Lengths past the cap are clipped when stored.
    dir_rows[11] = mkrow(OP_LOAD,     2, 32'h80000001, 63, 1, 0, 0, 0, 0);
    dir_rows[12] = mkrow(OP_ENCODE,   2, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[13] = mkrow(OP_LOAD,     3, 32'h00000005, 0, 1, 0, 0, 0, 0);
    dir_rows[14] = mkrow(OP_ENCODE,   3, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[15] = mkrow(OP_LOAD,     4, 32'h00000001, 1, 1, 0, 0, 0, 0);
    dir_rows[16] = mkrow(OP_ENCODE,   4, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[17] = mkrow(OP_ENCODE,   2, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[18] = mkrow(OP_LOAD,     0, 32'h0000DEAD, 5, 0, 0, 0, 0, 0);
    dir_rows[19] = mkrow(OP_ENCODE,   0, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[20] = mkrow(OP_LOAD,     5, 32'hFFFFFFFF, 33, 1, 0, 0, 0, 0);
    dir_rows[21] = mkrow(OP_ENCODE,   5, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[22] = mkrow(OP_FLUSH,    0, 32'h0,        0, 0, 0, 0, 0, 0);
    dir_rows[23] = mkrow(OP_FLUSH,    0, 32'h0,        0, 0, 1, 8'h00, 0, 32'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 15;
    out_idle_pct = 77;
    for (int i = 0; i < N_ROWS; i++)
      send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

    // Three idling phases; the last one also holds the receiver off for a long stretch
    // while transactions keep coming, so the block backs up into its input.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin
        in_idle_pct = 15;
        out_idle_pct = 77;
        target = 69;
      end else if (ph == 1) begin
        in_idle_pct = 77;
        out_idle_pct = 15;
        target = 69;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
        target = 68;
        stall_req = 1'b1;
      end
      phase_items = 0;
      while (phase_items < target) begin
        c = random_cmd();
        send_cmd(c, 1'b0, none);
        phase_items++;
      end
    end

    in_ch.valid <= 1'b0;
    while (exp_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (exp_bytes_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, exp_bytes_q.size());
    end
    $display("Covered %0d table loads, %0d encodes, %0d flushes, %0d unused operations.",
             n_load, n_encode, n_flush, n_ignored);
    $display("Checked %0d output transactions; %0d mismatches.", n_bytes_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hte_pkg.sv
rtl/hte_if.sv
rtl/hte_table.sv
rtl/hte_packer.sv
rtl/huffman_table_encoder_packer_unit.sv
sim/tb_top.sv
